@@ sv/pcm_pkg.sv @@
// Shared types, constants and helpers for the partial core mask table builder.
`default_nettype none

package pcm_pkg;

  localparam int MASK_W       = 31;
  localparam int COUNT_W      = 4;
  localparam int INDEX_W      = 3;
  localparam int STACK_IDX_W  = 3;
  localparam int MISS_W       = 3;

  localparam int DEF_MAX_POINTS  = 8;
  localparam int DEF_STACK_COUNT = 6;

  localparam int CORES_PER_STACK = 4;
  localparam int BASE_STACKS     = 2;
  localparam int LOW_GROUP       = 3;
  localparam int HIGH_OFFSET     = 16;
  localparam logic [MASK_W-1:0] UNIT_MASK = MASK_W'(32'h1111);

  typedef struct packed {
    logic [MASK_W-1:0]  present_mask;
    logic [COUNT_W-1:0] opp_count;
  } in_item_t;

  typedef struct packed {
    logic               enabled;
    logic [INDEX_W-1:0] point_index;
    logic [MASK_W-1:0]  point_mask;
    logic [COUNT_W-1:0] points_left;
    logic               last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_CHECK,
    ST_SWEEP
  } state_t;

  // Core positions of one stack: three low stacks at bits 0..2, the rest from bit 16.
  function automatic logic [MASK_W-1:0] stack_cores(logic [STACK_IDX_W-1:0] s);
    logic [4:0] offset;
    offset = (s < STACK_IDX_W'(LOW_GROUP)) ? 5'(s) : 5'(s) + 5'(HIGH_OFFSET - LOW_GROUP);
    return UNIT_MASK << offset;
  endfunction

endpackage

`default_nettype wire

@@ sv/partial_core_mask_table_builder.sv @@
// Top level: builds the per-point core mask table from a shader-present mask.
//
// Usage: drive in_item and raise start while busy is low; the item is taken on
// that clock edge and busy stays high until the run is over. Results come out
// on out_item, one per cycle in which out_valid is high, and the receiver has
// to take each of them in that cycle; it cannot stall the block.
// A run first counts the missing cores of one stack per cycle, through one
// shared counter, then makes the cut and the disable checks in the check state.
// A disabled run gives its single result, registered, from that state. Otherwise
// a sweep visits one (miss level, stack) pair per cycle, in the order of fewest
// missing cores and then stack index, and emits the mask of point i when the
// (i+2)th stack is taken. The sweep ends at the last point.
// Reset clears the sequencer and the result strobe; nothing else persists
// from one item to the next.
`default_nettype none

module partial_core_mask_table_builder #(
  parameter int MAX_POINTS  = pcm_pkg::DEF_MAX_POINTS,
  parameter int STACK_COUNT = pcm_pkg::DEF_STACK_COUNT
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire pcm_pkg::in_item_t  in_item,
  output logic                    out_valid,
  output pcm_pkg::out_item_t      out_item
);
  import pcm_pkg::*;

  localparam int SW    = (STACK_COUNT > 1) ? $clog2(STACK_COUNT) : 1;
  localparam int TW    = $clog2(CORES_PER_STACK * STACK_COUNT + 1);
  localparam int CMPW  = ((TW > COUNT_W) ? TW : COUNT_W) + 1;
  localparam int MAX_MISS = CORES_PER_STACK;

  state_t              state_r, state_nxt;
  logic [MASK_W-1:0]   present_r, present_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]  left_r, left_nxt;
  logic [SW-1:0]       s_r, s_nxt;
  logic [MISS_W-1:0]   lvl_r, lvl_nxt;
  logic [STACK_IDX_W-1:0] taken_r, taken_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  logic [MISS_W-1:0]   miss_r [STACK_COUNT];
  logic                miss_we;
  logic [MISS_W-1:0]   miss_new;
  logic [MASK_W-1:0]   acc_r, acc_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_item_r, out_item_nxt;

  // Shared unit: one stack's cores under the present mask.
  logic [MASK_W-1:0]   cur_cores;
  logic [MISS_W-1:0]   have;

  logic [COUNT_W-1:0]  in_cnt_sat;
  logic [TW-3:0]       cut;
  logic [COUNT_W-1:0]  left_calc;
  logic                disable_run;
  logic                stack_hit;
  logic [STACK_IDX_W-1:0] taken_inc;
  logic [INDEX_W-1:0]  pidx;
  logic                is_last;
  logic                s_wrap;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign cur_cores = present_r & stack_cores(STACK_IDX_W'(s_r));
  assign have      = MISS_W'($countones(cur_cores));
  assign miss_new  = MISS_W'(MAX_MISS) - have;

  assign in_cnt_sat = (in_item.opp_count > COUNT_W'(MAX_POINTS)) ?
                      COUNT_W'(MAX_POINTS) : in_item.opp_count;

  assign cut       = total_r[TW-1:2];
  assign left_calc = cnt_r - COUNT_W'(cut);
  assign disable_run = (CMPW'(cut) >= CMPW'(cnt_r)) ||
                       ((CMPW'(left_calc) + CMPW'(1)) > CMPW'(STACK_COUNT)) ||
                       (total_r == TW'(CORES_PER_STACK * STACK_COUNT));

  assign stack_hit = (miss_r[s_r] == lvl_r);
  assign taken_inc = taken_r + STACK_IDX_W'(1);
  assign pidx      = INDEX_W'(taken_inc - STACK_IDX_W'(BASE_STACKS));
  assign is_last   = ({1'b0, pidx} == (left_r - COUNT_W'(1)));
  assign s_wrap    = (s_r == SW'(STACK_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    present_r  <= present_nxt;
    cnt_r      <= cnt_nxt;
    left_r     <= left_nxt;
    s_r        <= s_nxt;
    lvl_r      <= lvl_nxt;
    taken_r    <= taken_nxt;
    total_r    <= total_nxt;
    acc_r      <= acc_nxt;
    out_item_r <= out_item_nxt;
    if (miss_we) begin
      miss_r[s_r] <= miss_new;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    present_nxt   = present_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    s_nxt         = s_r;
    lvl_nxt       = lvl_r;
    taken_nxt     = taken_r;
    total_nxt     = total_r;
    acc_nxt       = acc_r;
    miss_we       = 1'b0;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          present_nxt = in_item.present_mask;
          cnt_nxt     = in_cnt_sat;
          s_nxt       = '0;
          lvl_nxt     = '0;
          taken_nxt   = '0;
          total_nxt   = '0;
          acc_nxt     = '0;
          state_nxt   = ST_COUNT;
        end
      end

      ST_COUNT: begin
        miss_we   = 1'b1;
        total_nxt = total_r + TW'(miss_new);
        if (s_wrap) begin
          s_nxt     = '0;
          state_nxt = ST_CHECK;
        end else begin
          s_nxt = s_r + SW'(1);
        end
      end

      ST_CHECK: begin
        left_nxt = left_calc;
        if (disable_run) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{enabled: 1'b0, point_index: '0, point_mask: '0,
                            points_left: '0, last: 1'b1};
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_SWEEP;
        end
      end

      ST_SWEEP: begin
        if (stack_hit) begin
          acc_nxt   = acc_r | cur_cores;
          taken_nxt = taken_inc;
          if (taken_inc >= STACK_IDX_W'(BASE_STACKS)) begin
            out_valid_nxt = 1'b1;
            out_item_nxt  = '{enabled: 1'b1, point_index: pidx,
                              point_mask: acc_r | cur_cores,
                              points_left: left_r, last: is_last};
            if (is_last) begin
              state_nxt = ST_IDLE;
            end
          end
        end
        if (s_wrap) begin
          s_nxt   = '0;
          lvl_nxt = lvl_r + MISS_W'(1);
          // The checks before the sweep guarantee the run ends first.
          if (lvl_r == MISS_W'(MAX_MISS)) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          s_nxt = s_r + SW'(1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // The final result of a run always leaves the block ready for the next item.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |-> !busy)
    else $error("block still busy after the final result");

  a_disabled_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.enabled |->
      out_item.last && (out_item.point_mask == '0) && (out_item.points_left == '0))
    else $error("disabled result is malformed");

  a_enabled_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.enabled |->
      (out_item.point_mask != '0) &&
      ({1'b0, out_item.point_index} < out_item.points_left))
    else $error("enabled result has an empty mask or a bad index");

  a_results_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last |-> busy)
    else $error("non-final result outside a run");

endmodule

`default_nettype wire

@@ tb/tb_partial_core_mask_table_builder.sv @@
// Self-checking testbench for the partial core mask table builder, with its own table predictor.
module tb_partial_core_mask_table_builder;
  timeunit 1ns;
  timeprecision 1ps;

  import pcm_pkg::*;

  localparam int N_STACKS        = 6;
  localparam int N_POINTS_MAX    = 8;
  localparam int CORES           = 4;
  localparam int FIRST_WANT      = 2;
  localparam int IDLE_PERCENT    = 29;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int SETTLE_CYCLES   = 40;
  localparam logic [MASK_W-1:0] STACK_UNIT = 31'h1111;
  localparam logic [MASK_W-1:0] CORE_BITS  = 31'h7777_7777;
  localparam logic [MASK_W-1:0] SPARE_BITS = 31'h0888_8888;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  out_item_t pending_points[$];
  out_item_t want_row;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  bit        sender_idles = 1'b1;

  partial_core_mask_table_builder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Low stacks sit at bits 0..2, the upper three start at bit 16.
  function automatic int stack_base(int s);
    return (s < 3) ? s : s - 3 + 16;
  endfunction

  function automatic logic [MASK_W-1:0] drop_cores(logic [MASK_W-1:0] m, int s, int n);
    for (int c = 0; c < n; c++) m[stack_base(s) + 4 * c] = 1'b0;
    return m;
  endfunction

  // Works out the whole result table of one item and queues it.
  function automatic void build_point_table(in_item_t it);
    int                miss[N_STACKS];
    int                total, cut, count, left, want, taken;
    logic [MASK_W-1:0] masks[N_POINTS_MAX];
    out_item_t         row;
    bit                dead;
    count = int'(it.opp_count);
    if (count > N_POINTS_MAX) count = N_POINTS_MAX;
    total = 0;
    for (int s = 0; s < N_STACKS; s++) begin
      miss[s] = CORES;
      for (int c = 0; c < CORES; c++)
        if (it.present_mask[stack_base(s) + 4 * c]) miss[s]--;
      total += miss[s];
    end
    cut = total / CORES;
    dead = (cut >= count);
    left = dead ? 0 : count - cut;
    for (int i = 0; i < left && !dead; i++) begin
      want = i + FIRST_WANT;
      masks[i] = '0;
      taken = 0;
      if (want > N_STACKS) begin
        dead = 1'b1;
      end else begin
        for (int lvl = 0; lvl <= CORES; lvl++)
          for (int s = 0; s < N_STACKS; s++)
            if (taken < want && miss[s] == lvl) begin
              masks[i] |= it.present_mask & (STACK_UNIT << stack_base(s));
              taken++;
            end
        if (masks[i] == '0) dead = 1'b1;
      end
    end
    if (dead) begin
      row = '0;
      row.last = 1'b1;
      pending_points.push_back(row);
    end else begin
      for (int i = 0; i < left; i++) begin
        row.enabled     = 1'b1;
        row.point_index = INDEX_W'(i);
        row.point_mask  = masks[i];
        row.points_left = COUNT_W'(left);
        row.last        = (i == left - 1);
        pending_points.push_back(row);
      end
    end
  endfunction

  // Start is left high after acceptance; the next call either drives a new item
  // in the same step or drops start for an idle gap.
  task automatic send_item(logic [MASK_W-1:0] m, int count);
    in_item_t it;
    it.present_mask = m;
    it.opp_count    = COUNT_W'(count);
    if (sender_idles)
      while ($urandom_range(99) < IDLE_PERCENT) begin
        start <= 1'b0;
        @(posedge clk);
      end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    build_point_table(it);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
  endtask

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_item);
        mismatches++;
      end else begin
        want_row = pending_points.pop_front();
        check_field("enabled", 32'(want_row.enabled), 32'(out_item.enabled));
        check_field("point_index", 32'(want_row.point_index), 32'(out_item.point_index));
        check_field("point_mask", 32'(want_row.point_mask), 32'(out_item.point_mask));
        check_field("points_left", 32'(want_row.points_left), 32'(out_item.points_left));
        check_field("last", 32'(want_row.last), 32'(out_item.last));
      end
    end
  end

  // Ends a hung run: counts cycles in which no item goes in and no result comes out.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Full masks over every point count, including saturation of large counts.
  task automatic test_point_counts();
    for (int n = 0; n <= N_POINTS_MAX; n++) send_item(31'h7FFF_FFFF, n);
    send_item(31'h7FFF_FFFF, 15);
    send_item(CORE_BITS, 3);
  endtask

  task automatic test_disable_cases();
    send_item('0, 8);              // every core missing, the run is disabled
    send_item(SPARE_BITS, 8);      // only bits outside the stacks
    send_item(SPARE_BITS, 0);
    send_item('0, 15);
    send_item(drop_cores(CORE_BITS, 2, 4), 1);   // cut equals the count
    send_item(drop_cores(CORE_BITS, 2, 4), 2);   // one point survives
    send_item(drop_cores(drop_cores(CORE_BITS, 0, 4), 5, 4), 3);
  endtask

  // Equal miss counts must go to the lower stack index first.
  task automatic test_stack_order();
    logic [MASK_W-1:0] m;
    m = drop_cores(drop_cores(drop_cores(CORE_BITS, 0, 1), 2, 1), 4, 1);
    send_item(m, 5);
    m = drop_cores(drop_cores(drop_cores(CORE_BITS, 0, 3), 1, 2), 2, 1);
    m = drop_cores(drop_cores(m, 3, 1), 4, 2);
    send_item(m, 7);
    send_item(m | SPARE_BITS, 6);
    m = drop_cores(drop_cores(drop_cores(CORE_BITS, 5, 1), 4, 1), 3, 1);
    send_item(m, 4);
  endtask

  // Mostly complete stacks with a few cores knocked out, so that runs reach the sweep.
  task automatic test_random_wellformed(int n_items);
    logic [MASK_W-1:0] m;
    int                k, count;
    for (int j = 0; j < n_items; j++) begin
      sender_idles = !(j >= n_items / 3 && j < 2 * n_items / 3);
      m = CORE_BITS | (SPARE_BITS & MASK_W'($urandom));
      k = $urandom_range(0, 8);
      for (int d = 0; d < k; d++)
        m[stack_base($urandom_range(0, N_STACKS - 1)) + 4 * $urandom_range(0, CORES - 1)] = 1'b0;
      count = ($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      send_item(m, count);
    end
    sender_idles = 1'b1;
  endtask

  task automatic test_random_noise(int n_items);
    for (int j = 0; j < n_items; j++)
      send_item(MASK_W'($urandom), $urandom_range(0, 15));
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_point_counts();
    test_disable_cases();
    wait_for_drain();
    test_stack_order();
    test_random_wellformed(100);
    wait_for_drain();
    test_random_noise(30);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/pcm_pkg.sv
sv/partial_core_mask_table_builder.sv
tb/tb_partial_core_mask_table_builder.sv
